/* src/dd_pkg.sv */
// Package for the date difference block: constants, status codes and calendar tables.
package dd_pkg;

	localparam int DEF_YEAR_BITS = 12;
	localparam int MIN_YEAR_RST  = 1600;
	localparam int MAX_YEAR_RST  = 3000;

	localparam int DAY_BITS   = 5;
	localparam int MONTH_BITS = 4;
	localparam int COUNT_BITS = 21;
	localparam int CFG_IDX_BITS = 2;

	// floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT holds for every x below 91180.
	localparam int DIV100_MUL   = 83887;
	localparam int DIV100_SHIFT = 23;
	localparam int DIV100_MUL_BITS = 17;

	localparam int DAYS_PER_YEAR = 365;

	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_YEAR = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_YEAR = 2'd1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_START_BAD = 2'd1,
		ST_END_BAD   = 2'd2,
		ST_ORDER     = 2'd3
	} status_t;

	function automatic logic [DAY_BITS-1:0] month_days(input logic [MONTH_BITS-1:0] m,
			input logic leap);
		logic [DAY_BITS-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2: n = leap ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_BITS-1:0] m);
		logic [8:0] n;
		unique case (m)
			4'd1:  n = 9'd0;
			4'd2:  n = 9'd31;
			4'd3:  n = 9'd59;
			4'd4:  n = 9'd90;
			4'd5:  n = 9'd120;
			4'd6:  n = 9'd151;
			4'd7:  n = 9'd181;
			4'd8:  n = 9'd212;
			4'd9:  n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			4'd12: n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

/* src/dd_date_if.sv */
// Input channel carrying one start and end date pair per word.
interface dd_date_if #(
	parameter int YEAR_BITS = dd_pkg::DEF_YEAR_BITS
);
	logic                          valid;
	logic                          ready;
	logic [dd_pkg::DAY_BITS-1:0]   start_day;
	logic [dd_pkg::MONTH_BITS-1:0] start_month;
	logic [YEAR_BITS-1:0]          start_year;
	logic [dd_pkg::DAY_BITS-1:0]   end_day;
	logic [dd_pkg::MONTH_BITS-1:0] end_month;
	logic [YEAR_BITS-1:0]          end_year;

	modport source (output valid, start_day, start_month, start_year,
		end_day, end_month, end_year, input ready);
	modport sink (input valid, start_day, start_month, start_year,
		end_day, end_month, end_year, output ready);
endinterface

/* src/dd_count_if.sv */
// Output channel carrying one day count and status per word.
interface dd_count_if;
	logic                          valid;
	logic                          ready;
	logic [dd_pkg::COUNT_BITS-1:0] day_count;
	logic [1:0]                    status;

	modport source (output valid, day_count, status, input ready);
	modport sink (input valid, day_count, status, output ready);
endinterface

/* src/dd_date_unit.sv */
// Three-stage date checker and day ordinal calculator for one date.
module dd_date_unit #(
	parameter int YEAR_BITS = dd_pkg::DEF_YEAR_BITS,
	localparam int ORD_BITS = YEAR_BITS + 9
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [dd_pkg::DAY_BITS-1:0]   day,
	input  logic [dd_pkg::MONTH_BITS-1:0] month,
	input  logic [YEAR_BITS-1:0]          year,
	input  logic [YEAR_BITS-1:0]          min_year,
	input  logic [YEAR_BITS-1:0]          max_year,
	output logic [ORD_BITS-1:0]           ordinal,
	output logic                          ok
);
	localparam int PROD_BITS = YEAR_BITS + dd_pkg::DIV100_MUL_BITS;

	// Stage 1: range checks and the reciprocal product for year / 100.
	logic [dd_pkg::DAY_BITS-1:0]   day_s1;
	logic [dd_pkg::MONTH_BITS-1:0] month_s1;
	logic [YEAR_BITS-1:0]          year_s1;
	logic [PROD_BITS-1:0]          prod_s1;
	logic                          range_ok_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			day_s1      <= day;
			month_s1    <= month;
			year_s1     <= year;
			prod_s1     <= PROD_BITS'(year) *
				PROD_BITS'(dd_pkg::DIV100_MUL);
			range_ok_s1 <= (year >= min_year) && (year <= max_year) &&
				(month >= 4'd1) && (month <= 4'd12);
		end
	end

	// Stage 2: leap rule, day check, day of year and the century terms.
	logic [YEAR_BITS-1:0] cent;
	logic [YEAR_BITS-1:0] rem_full;
	logic                 rem_nz;
	logic                 leap;
	logic [9:0]           doy;

	assign cent     = YEAR_BITS'(prod_s1[PROD_BITS-1:dd_pkg::DIV100_SHIFT]);
	assign rem_full = year_s1 - YEAR_BITS'(cent * YEAR_BITS'(100));
	assign rem_nz   = rem_full[6:0] != 7'd0;
	assign leap     = (year_s1[1:0] == 2'b00 && rem_nz) ||
		(!rem_nz && cent[1:0] == 2'b00);
	assign doy      = {1'b0, dd_pkg::days_before(month_s1)} +
		10'((month_s1 > 4'd2) && leap) + {5'b0, day_s1} - 10'd1;

	logic [YEAR_BITS-1:0] year_s2;
	logic [YEAR_BITS-1:0] ceil100_s2;
	logic [YEAR_BITS-1:0] ceil400_s2;
	logic [8:0]           doy_s2;
	logic                 ok_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			year_s2    <= year_s1;
			ceil100_s2 <= cent + YEAR_BITS'(rem_nz);
			ceil400_s2 <= (cent >> 2) + YEAR_BITS'(rem_nz || cent[1:0] != 2'b00);
			doy_s2     <= doy[8:0];
			ok_s2      <= range_ok_s1 && (day_s1 != 5'd0) &&
				(day_s1 <= dd_pkg::month_days(month_s1, leap));
		end
	end

	// Stage 3: ordinal counted from the first day of year 0.
	logic [YEAR_BITS+1:0] y_plus3;
	logic [ORD_BITS-1:0]  ord_next;

	assign y_plus3  = {2'b00, year_s2} + (YEAR_BITS+2)'(3);
	assign ord_next = ORD_BITS'(year_s2) * ORD_BITS'(dd_pkg::DAYS_PER_YEAR) +
		ORD_BITS'(y_plus3 >> 2) - ORD_BITS'(ceil100_s2) +
		ORD_BITS'(ceil400_s2) + ORD_BITS'(doy_s2);

	logic [ORD_BITS-1:0] ord_s3;
	logic                ok_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ord_s3 <= ord_next;
			ok_s3  <= ok_s2;
		end
	end

	assign ordinal = ord_s3;
	assign ok      = ok_s3;
endmodule

/* src/date_difference_days.sv */
// Top level of the Gregorian day difference block.
//
//   channel   direction  word
//   dates     in         start_day, start_month, start_year, end_day, end_month, end_year
//   result    out        day_count, status
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// Each word passes through three stages of the date units, then the
// compare and subtract stage that holds the output.
// One word is accepted in every cycle while the output stage is empty or being taken.
// A stall at the output holds all four stages at once; nothing is dropped.
// Reset clears the valid bits and loads the year range with 1600 to 3000.
module date_difference_days #(
	parameter int YEAR_BITS = dd_pkg::DEF_YEAR_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [YEAR_BITS-1:0]            cfg_data,
	dd_date_if.sink                         dates,
	dd_count_if.source                      result
);
	localparam int ORD_BITS = YEAR_BITS + 9;

	logic [YEAR_BITS-1:0] min_year_q;
	logic [YEAR_BITS-1:0] max_year_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= YEAR_BITS'(dd_pkg::MIN_YEAR_RST);
			max_year_q <= YEAR_BITS'(dd_pkg::MAX_YEAR_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				dd_pkg::REG_MIN_YEAR: min_year_q <= cfg_data;
				dd_pkg::REG_MAX_YEAR: max_year_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	// The whole pipe moves when the output stage is empty or being taken.
	assign adv          = !v_s4 || result.ready;
	assign dates.ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dates.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	logic [ORD_BITS-1:0] ord_a, ord_b;
	logic                ok_a, ok_b;

	dd_date_unit #(.YEAR_BITS(YEAR_BITS)) u_start (
		.clk      (clk),
		.en       (adv),
		.day      (dates.start_day),
		.month    (dates.start_month),
		.year     (dates.start_year),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.ordinal  (ord_a),
		.ok       (ok_a)
	);

	dd_date_unit #(.YEAR_BITS(YEAR_BITS)) u_end (
		.clk      (clk),
		.en       (adv),
		.day      (dates.end_day),
		.month    (dates.end_month),
		.year     (dates.end_year),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.ordinal  (ord_b),
		.ok       (ok_b)
	);

	// Start faults win over end faults, and both over the ordering check.
	dd_pkg::status_t              status_next;
	logic [dd_pkg::COUNT_BITS-1:0] count_next;
	logic [ORD_BITS-1:0]          diff;

	assign diff = ord_b - ord_a;

	always_comb begin
		count_next = '0;
		priority if (!ok_a) begin
			status_next = dd_pkg::ST_START_BAD;
		end else if (!ok_b) begin
			status_next = dd_pkg::ST_END_BAD;
		end else if (ord_a > ord_b) begin
			status_next = dd_pkg::ST_ORDER;
		end else begin
			status_next = dd_pkg::ST_OK;
			count_next  = dd_pkg::COUNT_BITS'(diff);
		end
	end

	logic [dd_pkg::COUNT_BITS-1:0] count_s4;
	dd_pkg::status_t              status_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			count_s4  <= count_next;
			status_s4 <= status_next;
		end
	end

	assign result.valid     = v_s4;
	assign result.day_count = count_s4;
	assign result.status    = status_s4;
endmodule
